[src/ira_pkg.sv]
// ira_pkg: shared constants, codes and types of the indexed record array.
// Used by the cell, the controller, the top level and the port checker.
// No dependencies.
package ira_pkg;

   // built size of the array and width of a stored key
   localparam int DEPTH    = 64;
   localparam int KEY_BITS = 16;

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // field widths of the words on the stream ports
   localparam int ACT_BITS    = 3;
   localparam int POS_BITS    = 7;
   localparam int KEYF_BITS   = 16;
   localparam int MARKS_BITS  = 16;
   localparam int GRADE_BITS  = 10;
   localparam int STAT_BITS   = 2;
   localparam int INDEX_BITS  = 6;
   localparam int COUNT_BITS  = 7;
   localparam int CAP_BITS    = 7;
   localparam int REQ_DBITS   = 56;
   localparam int RSP_DBITS   = 64;
   localparam int CSR_ABITS   = 3;
   localparam int CSR_DBITS   = 32;

   localparam int CMP_BITS = (KEY_BITS > KEYF_BITS) ? KEY_BITS : KEYF_BITS;

   localparam logic [GRADE_BITS-1:0] GRADE_MAX = 10'd1000;
   localparam logic [CAP_BITS-1:0]   CAP_RESET = 7'd64;

   // action codes
   localparam logic [ACT_BITS-1:0] ACT_INSERT   = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_DELETE   = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_SEARCH   = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_UPDATE   = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_TRAVERSE = 3'd4;

   // status codes
   localparam logic [STAT_BITS-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_FAIL = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_MISS = 2'd2;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [MARKS_BITS-1:0] marks;
      logic [GRADE_BITS-1:0] grade;
   } rec_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_DELETE = 3'd2,
      CELL_WRITE  = 3'd3,
      CELL_ROTATE = 3'd4
   } cell_op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type         op;
      logic [POS_BITS-1:0] pos;
      logic [CNT_BITS-1:0] used;
      rec_type             wr_rec;
   } cell_cmd_type;

endpackage

[src/indexed_record_array_core.sv]
// indexed_record_array_core: top level; capacity register on the APB-style
// port, row of ira_cell entries and the ira_ctrl sequencer. Uses ira_pkg.
//
//  - req_ channel: one word per action. tuser carries the action code,
//    tdata the position, key, marks and grade.
//  - rsp_ channel: one word per action, or one word per stored record on a
//    traverse (tlast marks the final word; an empty traverse gives a single
//    word with count 0).
//  - Insert, delete and update: all cells shift or write at once; for these
//    and unknown actions the result is in the output register the next cycle.
//  - Search: each probe is a registered row read (S_SEARCH), then a compare
//    (S_CMP), up to log2(DEPTH)+1 probes; a miss is reported from S_SEARCH.
//  - Traverse: one word per cycle while the receiver takes them; the used run
//    rotates one cell per word and is back in place after the final word. Up to DEPTH words.
//  - req_tready is high when idle and the output register is empty or being
//    taken in the same cycle; search and traverse hold it low while busy.
//  - Receiver stall: the output word holds and the sequencer waits.
//  - Reset: entry count to zero, capacity to 64; records are not cleared, entries beyond
//    the count are never read. Capacity must be written idle only; the block does not enforce it.
module indexed_record_array_core import ira_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request: tdata = position[6:0], key[22:7], marks[38:23], grade[48:39]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_DBITS-1:0] req_tdata,
   // request: tuser = action[2:0]
   input  logic [ACT_BITS-1:0]  req_tuser,
   // response: tdata = status[1:0], index[7:2], rec_key[23:8],
   //                   rec_marks[39:24], rec_grade[49:40], count[56:50]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_DBITS-1:0] rsp_tdata,
   output logic                 rsp_tlast,
   // configuration: capacity at byte address 0
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_ABITS-1:0] csr_paddr,
   input  logic [CSR_DBITS-1:0] csr_pwdata,
   output logic [CSR_DBITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   logic [CAP_BITS-1:0] capacity_ff, capacity_in;
   logic                csr_wr;
   cell_cmd_type        cmd;
   rec_type             cell_rec [DEPTH];

   // register write on the access phase; pready is tied high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && !csr_paddr[2]) begin
         capacity_in = csr_pwdata[CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DBITS'(capacity_ff);

   ira_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cell_rec   (cell_rec),
      .cmd        (cmd)
   );

   // row of cells; each sees its neighbours and the head of the row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;

      if (g == 0) begin : g_first
         assign left_rec = '0;
      end else begin : g_inner_l
         assign left_rec = cell_rec[g-1];
      end

      if (g == DEPTH - 1) begin : g_final
         assign right_rec = '0;
      end else begin : g_inner_r
         assign right_rec = cell_rec[g+1];
      end

      ira_cell u_cell (
         .clock     (clock),
         .cell_idx  (IDX_BITS'(g)),
         .cmd       (cmd),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .head_rec  (cell_rec[0]),
         .rec_out   (cell_rec[g])
      );
   end

endmodule

[src/ira_cell.sv]
// ira_cell: one entry of the record row; takes its neighbour's record on a
// shift or rotate, or the broadcast record on a write. Depends on ira_pkg.
module ira_cell import ira_pkg::*; (
   input  logic                clock,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  cell_cmd_type        cmd,
   input  rec_type             left_rec,
   input  rec_type             right_rec,
   input  rec_type             head_rec,
   output rec_type             rec_out
);

   rec_type             rec_ff;
   rec_type             rec_in;
   logic [POS_BITS-1:0] idx;
   logic [POS_BITS-1:0] idx_next;
   logic [POS_BITS-1:0] used;

   assign idx      = POS_BITS'(cell_idx);
   assign idx_next = idx + POS_BITS'(1);
   assign used     = POS_BITS'(cmd.used);

   always_comb begin
      rec_in = rec_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (idx == cmd.pos) begin
               rec_in = cmd.wr_rec;
            end else if (idx > cmd.pos && idx <= used) begin
               rec_in = left_rec;
            end
         end
         CELL_DELETE: begin
            if (idx >= cmd.pos && idx_next < used) begin
               rec_in = right_rec;
            end
         end
         CELL_WRITE: begin
            if (idx == cmd.pos) begin
               rec_in = cmd.wr_rec;
            end
         end
         CELL_ROTATE: begin
            // tail of the used run wraps to the head's record
            if (idx_next < used) begin
               rec_in = right_rec;
            end else if (idx_next == used) begin
               rec_in = head_rec;
            end
         end
         default: rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

[src/ira_ctrl.sv]
// ira_ctrl: action decode, entry count, binary search walker, traverse
// sequencer and the result word register. Depends on ira_pkg.
module ira_ctrl import ira_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CAP_BITS-1:0]  capacity,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_DBITS-1:0] req_tdata,
   input  logic [ACT_BITS-1:0]  req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_DBITS-1:0] rsp_tdata,
   output logic                 rsp_tlast,
   input  rec_type              cell_rec [DEPTH],
   output cell_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_CMP    = 4'b0100,
      S_TRAV   = 4'b1000
   } fsm_type;

   fsm_type                state_ff, state_in;
   logic [CNT_BITS-1:0]    used_ff, used_in;
   logic [CNT_BITS-1:0]    lo_ff, lo_in;
   logic [CNT_BITS-1:0]    hi_ff, hi_in;
   logic [KEYF_BITS-1:0]   target_ff, target_in;
   logic [IDX_BITS-1:0]    trav_ff, trav_in;
   logic [IDX_BITS-1:0]    mid_ff, mid_in;
   rec_type                probe_ff, probe_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DBITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [POS_BITS-1:0]    req_pos;
   logic [KEYF_BITS-1:0]   req_key;
   logic [MARKS_BITS-1:0]  req_marks;
   logic [GRADE_BITS-1:0]  req_grade;
   logic                   out_free;
   logic                   accept;
   logic [POS_BITS-1:0]    used_w;
   logic [POS_BITS-1:0]    cap_lim;
   logic [CNT_BITS:0]      mid_sum;
   logic [IDX_BITS-1:0]    mid;
   logic [CMP_BITS-1:0]    probe_key;
   logic [CMP_BITS-1:0]    tgt;
   rec_type                head;
   logic                   trav_last;

   function automatic logic [RSP_DBITS-1:0] pack_rsp(
      input logic [STAT_BITS-1:0]  status,
      input logic [INDEX_BITS-1:0] index,
      input rec_type               rec,
      input logic [CNT_BITS-1:0]   count
   );
      pack_rsp = {7'd0, COUNT_BITS'(count), rec.grade, rec.marks,
                  KEYF_BITS'(rec.key), index, status};
   endfunction

   assign req_pos   = req_tdata[6:0];
   assign req_key   = req_tdata[22:7];
   assign req_marks = req_tdata[38:23];
   assign req_grade = req_tdata[48:39];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign used_w  = POS_BITS'(used_ff);
   assign cap_lim = (capacity > POS_BITS'(DEPTH)) ? POS_BITS'(DEPTH) : capacity;

   // search probe: midpoint of the half-open range [lo, hi); the row entry is
   // registered first and compared in the following cycle
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_BITS+1)'(1);
   assign mid       = IDX_BITS'(mid_sum >> 1);
   assign probe_key = CMP_BITS'(probe_ff.key);
   assign tgt       = CMP_BITS'(target_ff);

   assign head      = cell_rec[0];
   assign trav_last = (POS_BITS'(trav_ff) + POS_BITS'(1)) == used_w;

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      target_in    = target_ff;
      trav_in      = trav_ff;
      mid_in       = mid_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      cmd.op           = CELL_HOLD;
      cmd.pos          = req_pos;
      cmd.used         = used_ff;
      cmd.wr_rec.key   = KEY_BITS'(req_key);
      cmd.wr_rec.marks = req_marks;
      cmd.wr_rec.grade = (req_grade > GRADE_MAX) ? GRADE_MAX : req_grade;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = pack_rsp(STAT_FAIL, '0, '0, used_ff);
               case (req_tuser)
                  ACT_INSERT: begin
                     if (used_w < cap_lim && req_pos <= used_w) begin
                        cmd.op      = CELL_INSERT;
                        used_in     = used_ff + CNT_BITS'(1);
                        rsp_data_in = pack_rsp(STAT_OK, '0, '0, used_in);
                     end
                  end
                  ACT_DELETE: begin
                     if (req_pos < used_w) begin
                        cmd.op      = CELL_DELETE;
                        used_in     = used_ff - CNT_BITS'(1);
                        rsp_data_in = pack_rsp(STAT_OK, '0, '0, used_in);
                     end
                  end
                  ACT_UPDATE: begin
                     if (req_pos < used_w) begin
                        cmd.op      = CELL_WRITE;
                        rsp_data_in = pack_rsp(STAT_OK, '0, '0, used_ff);
                     end
                  end
                  ACT_SEARCH: begin
                     if (used_ff == '0) begin
                        rsp_data_in = pack_rsp(STAT_MISS, '0, '0, used_ff);
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        rsp_data_in  = rsp_data_ff;
                        rsp_last_in  = rsp_last_ff;
                        lo_in        = '0;
                        hi_in        = used_ff;
                        target_in    = req_key;
                        state_in     = S_SEARCH;
                     end
                  end
                  ACT_TRAVERSE: begin
                     if (used_ff == '0) begin
                        rsp_data_in = pack_rsp(STAT_OK, '0, '0, used_ff);
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        rsp_data_in  = rsp_data_ff;
                        rsp_last_in  = rsp_last_ff;
                        trav_in      = '0;
                        state_in     = S_TRAV;
                     end
                  end
                  default: rsp_data_in = pack_rsp(STAT_FAIL, '0, '0, used_ff);
               endcase
            end
         end
         S_SEARCH: begin
            if (out_free) begin
               if (lo_ff < hi_ff) begin
                  probe_in = cell_rec[mid];
                  mid_in   = mid;
                  state_in = S_CMP;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = pack_rsp(STAT_MISS, '0, '0, used_ff);
                  state_in     = S_IDLE;
               end
            end
         end
         S_CMP: begin
            if (out_free) begin
               state_in = S_SEARCH;
               if (tgt > probe_key) begin
                  lo_in = CNT_BITS'(mid_ff) + CNT_BITS'(1);
               end else if (tgt < probe_key) begin
                  hi_in = CNT_BITS'(mid_ff);
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = pack_rsp(STAT_OK, INDEX_BITS'(mid_ff), probe_ff, used_ff);
                  state_in     = S_IDLE;
               end
            end
         end
         S_TRAV: begin
            // head cell is emitted, then the used run rotates by one
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = trav_last;
               rsp_data_in  = pack_rsp(STAT_OK, INDEX_BITS'(trav_ff), head, used_ff);
               cmd.op       = CELL_ROTATE;
               trav_in      = trav_ff + IDX_BITS'(1);
               if (trav_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      target_ff   <= target_in;
      trav_ff     <= trav_in;
      mid_ff      <= mid_in;
      probe_ff    <= probe_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[src/ira_checker.sv]
// ira_checker: port-level checks on the result channel of the record array.
// Depends on ira_pkg; bound to indexed_record_array_core below.
module ira_checker import ira_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_DBITS-1:0] rsp_tdata,
   input logic                 rsp_tlast
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed under stall");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[56:50] <= COUNT_BITS'(DEPTH))
      else $error("count beyond depth");

   // failures and misses are single-word results
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STAT_OK |-> rsp_tlast)
      else $error("error status on a non-final word");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STAT_MISS |-> rsp_tdata[49:2] == '0)
      else $error("miss carries a record");

   // mid-traverse, no new request word is taken
   a_trav_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during traverse");

endmodule

bind indexed_record_array_core ira_checker u_ira_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
